@@ hdl/greedy_byte_string_diff_defines.svh @@
// Assertion macros shared by the greedy byte diff RTL.
`ifndef GREEDY_BYTE_STRING_DIFF_DEFINES_SVH
`define GREEDY_BYTE_STRING_DIFF_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GBD_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("gbd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GBD_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("gbd: next-cycle check failed");

`endif

@@ hdl/gbd_pkg.sv @@
// Shared constants, types and the microcode table of the greedy byte diff.
package gbd_pkg;

    localparam int MAX_LEN = 32;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int BYTE_W  = 8;
    localparam int FUNC_W  = 2;
    localparam int KIND_W  = 2;
    localparam int UPC_W   = 4;

    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_LEN);
    localparam logic [CNT_W-1:0] MAX_RUNS = CNT_W'(32);

    // input function codes
    localparam logic [FUNC_W-1:0] FN_LOAD_B = 2'd0;
    localparam logic [FUNC_W-1:0] FN_LOAD_A = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CMP    = 2'd2;

    // run kinds
    localparam logic [KIND_W-1:0] KIND_DEL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END = 2'd2;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_CMP,
        C_B_DONE,
        C_A_DONE,
        C_NEQ,
        C_J_END
    } gbd_cond_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_IDLE,
        ACT_MATCH,
        ACT_SETJ,
        ACT_SCAN,
        ACT_EMIT_DEL,
        ACT_EMIT_INS,
        ACT_INCJ,
        ACT_DEL_MARK,
        ACT_DEL_TAIL,
        ACT_FIN_DEL,
        ACT_FIN_INS,
        ACT_END
    } gbd_act_t;

    typedef struct packed {
        gbd_cond_t        cond;
        gbd_act_t         act;
        logic [UPC_W-1:0] tgt;
    } gbd_uword_t;

    typedef struct packed {
        logic cmp_accept;
        logic b_done;
        logic a_done;
        logic neq;
        logic j_end;
    } gbd_flags_t;

    // microcode addresses
    localparam logic [UPC_W-1:0] UA_IDLE  = 4'd0;
    localparam logic [UPC_W-1:0] UA_TOP   = 4'd1;
    localparam logic [UPC_W-1:0] UA_CHKA  = 4'd2;
    localparam logic [UPC_W-1:0] UA_CMP   = 4'd3;
    localparam logic [UPC_W-1:0] UA_MATCH = 4'd4;
    localparam logic [UPC_W-1:0] UA_MISS  = 4'd5;
    localparam logic [UPC_W-1:0] UA_SCAN  = 4'd6;
    localparam logic [UPC_W-1:0] UA_SCHK  = 4'd7;
    localparam logic [UPC_W-1:0] UA_FOUND = 4'd8;
    localparam logic [UPC_W-1:0] UA_INS   = 4'd9;
    localparam logic [UPC_W-1:0] UA_INCJ  = 4'd10;
    localparam logic [UPC_W-1:0] UA_NOTF  = 4'd11;
    localparam logic [UPC_W-1:0] UA_TAIL  = 4'd12;
    localparam logic [UPC_W-1:0] UA_FIN   = 4'd13;
    localparam logic [UPC_W-1:0] UA_FINI  = 4'd14;
    localparam logic [UPC_W-1:0] UA_END   = 4'd15;

    // Control store. A word jumps to tgt when its condition holds,
    // otherwise falls through to the next address.
    function automatic gbd_uword_t uc_rom(input logic [UPC_W-1:0] addr);
        gbd_uword_t w;
        w = '{cond: C_NEXT, act: ACT_NONE, tgt: UA_IDLE};
        unique case (addr)
            UA_IDLE:  w = '{cond: C_NO_CMP, act: ACT_IDLE,     tgt: UA_IDLE};
            UA_TOP:   w = '{cond: C_B_DONE, act: ACT_NONE,     tgt: UA_FIN};
            UA_CHKA:  w = '{cond: C_A_DONE, act: ACT_NONE,     tgt: UA_TAIL};
            UA_CMP:   w = '{cond: C_NEQ,    act: ACT_NONE,     tgt: UA_MISS};
            UA_MATCH: w = '{cond: C_ALWAYS, act: ACT_MATCH,    tgt: UA_TOP};
            UA_MISS:  w = '{cond: C_NEXT,   act: ACT_SETJ,     tgt: UA_IDLE};
            UA_SCAN:  w = '{cond: C_J_END,  act: ACT_SCAN,     tgt: UA_NOTF};
            UA_SCHK:  w = '{cond: C_NEQ,    act: ACT_NONE,     tgt: UA_INCJ};
            UA_FOUND: w = '{cond: C_NEXT,   act: ACT_EMIT_DEL, tgt: UA_IDLE};
            UA_INS:   w = '{cond: C_ALWAYS, act: ACT_EMIT_INS, tgt: UA_TOP};
            UA_INCJ:  w = '{cond: C_ALWAYS, act: ACT_INCJ,     tgt: UA_SCAN};
            UA_NOTF:  w = '{cond: C_ALWAYS, act: ACT_DEL_MARK, tgt: UA_TOP};
            UA_TAIL:  w = '{cond: C_ALWAYS, act: ACT_DEL_TAIL, tgt: UA_FIN};
            UA_FIN:   w = '{cond: C_NEXT,   act: ACT_FIN_DEL,  tgt: UA_IDLE};
            UA_FINI:  w = '{cond: C_NEXT,   act: ACT_FIN_INS,  tgt: UA_IDLE};
            UA_END:   w = '{cond: C_ALWAYS, act: ACT_END,      tgt: UA_IDLE};
            default:  w = '{cond: C_ALWAYS, act: ACT_NONE,     tgt: UA_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ hdl/gbd_if.sv @@
// Valid/ready channel interfaces for the load/compare input and the run output.
interface gbd_in_if;
    logic                        valid;
    logic                        ready;
    logic [gbd_pkg::FUNC_W-1:0]  func;
    logic [gbd_pkg::BYTE_W-1:0]  data_byte;

    modport source (output valid, func, data_byte, input ready);
    modport sink   (input valid, func, data_byte, output ready);
endinterface

interface gbd_out_if;
    logic                        valid;
    logic                        ready;
    logic [gbd_pkg::KIND_W-1:0]  run_kind;
    logic [gbd_pkg::ADDR_W-1:0]  run_start;
    logic [gbd_pkg::CNT_W-1:0]   run_length;
    logic                        overflow;
    logic                        last;

    modport source (output valid, run_kind, run_start, run_length, overflow, last,
                    input ready);
    modport sink   (input valid, run_kind, run_start, run_length, overflow, last,
                    output ready);
endinterface

@@ hdl/gbd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

@@ hdl/gbd_useq.sv @@
// Microprogram sequencer: step counter, control store and branch logic.
module gbd_useq (
    input  logic                clk,
    input  logic                rst_n,
    input  gbd_pkg::gbd_flags_t flags,
    input  logic                hold,
    output gbd_pkg::gbd_uword_t uword
);
    logic [gbd_pkg::UPC_W-1:0] upc_reg;
    logic [gbd_pkg::UPC_W-1:0] upc_next;
    logic                      take;

    assign uword = gbd_pkg::uc_rom(upc_reg);

    always_comb
    begin
        case (uword.cond)
            gbd_pkg::C_NEXT:   take = 1'b0;
            gbd_pkg::C_ALWAYS: take = 1'b1;
            gbd_pkg::C_NO_CMP: take = !flags.cmp_accept;
            gbd_pkg::C_B_DONE: take = flags.b_done;
            gbd_pkg::C_A_DONE: take = flags.a_done;
            gbd_pkg::C_NEQ:    take = flags.neq;
            gbd_pkg::C_J_END:  take = flags.j_end;
            default:           take = 1'b0;
        endcase

        if (hold)
        begin
            upc_next = upc_reg;
        end
        else if (take)
        begin
            upc_next = uword.tgt;
        end
        else
        begin
            upc_next = upc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= gbd_pkg::UA_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end
endmodule

@@ hdl/greedy_byte_string_diff.sv @@
// Greedy byte diff top level: load/compare input, run output, datapath and checks.
//
// Usage:
//   din carries one item per transfer: func 0 appends data_byte to the before
//   string, func 1 appends it to the after string, func 2 starts a compare,
//   func 3 is ignored. Each string holds up to 32 bytes; extra bytes are
//   dropped and the overflow bit is set on every result of the next compare.
//   dout carries one transfer per run (kind, start, length) for up to 32 runs,
//   then an end marker with last set. A compare of two empty strings gives only
//   the marker. din is ready whenever the sequencer idles; loads are taken there.
//   A compare runs a microprogram: a matched byte pair passes the top, check,
//   compare and match steps, and an after byte tried in a forward search passes
//   the scan, check and increment steps; the search loop through the after-store
//   read port sets the worst case. din stays low from compare acceptance until
//   the end marker is loaded into the output register. A stalled dout freezes
//   the sequencer at the emitting step; the result register holds until its
//   transfer completes. Reset empties both strings and clears the overflow flag;
//   the store contents are not cleared and no clearing pass is needed.
//   After the end marker both strings are empty again.

`include "greedy_byte_string_diff_defines.svh"

module greedy_byte_string_diff (
    input  logic       clk,
    input  logic       rst_n,
    gbd_in_if.sink     din,
    gbd_out_if.source  dout
);
    localparam int AW = gbd_pkg::ADDR_W;
    localparam int CW = gbd_pkg::CNT_W;

    gbd_pkg::gbd_uword_t uw;
    gbd_pkg::gbd_flags_t flags;
    logic                hold;

    // string lengths and flags
    logic [CW-1:0] before_count_reg, before_count_next;
    logic [CW-1:0] after_count_reg,  after_count_next;
    logic          overflow_reg,     overflow_next;

    // compare cursors
    logic [CW-1:0] bi_reg,     bi_next;
    logic [CW-1:0] ai_reg,     ai_next;
    logic [CW-1:0] j_reg,      j_next;
    logic [AW-1:0] dstart_reg, dstart_next;
    logic          dact_reg,   dact_next;
    logic [CW-1:0] runcnt_reg, runcnt_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [gbd_pkg::KIND_W-1:0]  out_kind_reg,  out_kind_next;
    logic [AW-1:0]               out_start_reg, out_start_next;
    logic [CW-1:0]               out_len_reg,   out_len_next;
    logic                        out_ovf_reg,   out_ovf_next;
    logic                        out_last_reg,  out_last_next;

    logic                        in_xfer;
    logic                        cmp_accept;
    logic                        we_b, we_a;
    logic [AW-1:0]               rd_addr_a;
    logic [gbd_pkg::BYTE_W-1:0]  rd_b, rd_a;

    logic                        emit_want, emit_go, out_free, is_end;
    logic [gbd_pkg::KIND_W-1:0]  emit_kind;
    logic [AW-1:0]               emit_start;
    logic [CW-1:0]               emit_len;
    logic [CW-1:0]               dstart_ext;

    assign din.ready  = (uw.act == gbd_pkg::ACT_IDLE);
    assign in_xfer    = din.valid && din.ready;
    assign cmp_accept = in_xfer && (din.func == gbd_pkg::FN_CMP);

    assign we_b = in_xfer && (din.func == gbd_pkg::FN_LOAD_B)
                  && (before_count_reg < gbd_pkg::MAX_CNT);
    assign we_a = in_xfer && (din.func == gbd_pkg::FN_LOAD_A)
                  && (after_count_reg < gbd_pkg::MAX_CNT);

    // the after port reads the search cursor only during the forward search
    assign rd_addr_a = (uw.act == gbd_pkg::ACT_SCAN) ? j_reg[AW-1:0] : ai_reg[AW-1:0];

    gbd_ram #(.WIDTH(gbd_pkg::BYTE_W), .DEPTH(gbd_pkg::MAX_LEN)) u_before_ram (
        .clk     (clk),
        .we      (we_b),
        .wr_addr (before_count_reg[AW-1:0]),
        .wr_data (din.data_byte),
        .rd_addr (bi_reg[AW-1:0]),
        .rd_data (rd_b)
    );

    gbd_ram #(.WIDTH(gbd_pkg::BYTE_W), .DEPTH(gbd_pkg::MAX_LEN)) u_after_ram (
        .clk     (clk),
        .we      (we_a),
        .wr_addr (after_count_reg[AW-1:0]),
        .wr_data (din.data_byte),
        .rd_addr (rd_addr_a),
        .rd_data (rd_a)
    );

    assign flags.cmp_accept = cmp_accept;
    assign flags.b_done     = (bi_reg >= before_count_reg);
    assign flags.a_done     = (ai_reg >= after_count_reg);
    assign flags.neq        = (rd_b != rd_a);
    assign flags.j_end      = (j_reg >= after_count_reg);

    gbd_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .hold  (hold),
        .uword (uw)
    );

    assign dstart_ext = {1'b0, dstart_reg};
    assign out_free   = !out_valid_reg || dout.ready;

    // result selection for the current step
    always_comb
    begin
        emit_want  = 1'b0;
        emit_kind  = gbd_pkg::KIND_DEL;
        emit_start = dstart_reg;
        emit_len   = bi_reg - dstart_ext;
        is_end     = 1'b0;
        case (uw.act)
            gbd_pkg::ACT_MATCH, gbd_pkg::ACT_EMIT_DEL, gbd_pkg::ACT_FIN_DEL:
            begin
                emit_want = dact_reg;
            end
            gbd_pkg::ACT_EMIT_INS:
            begin
                emit_want  = 1'b1;
                emit_kind  = gbd_pkg::KIND_INS;
                emit_start = ai_reg[AW-1:0];
                emit_len   = j_reg - ai_reg;
            end
            gbd_pkg::ACT_FIN_INS:
            begin
                emit_want  = (ai_reg < after_count_reg);
                emit_kind  = gbd_pkg::KIND_INS;
                emit_start = ai_reg[AW-1:0];
                emit_len   = after_count_reg - ai_reg;
            end
            gbd_pkg::ACT_END:
            begin
                emit_want  = 1'b1;
                is_end     = 1'b1;
                emit_kind  = gbd_pkg::KIND_END;
                emit_start = '0;
                emit_len   = '0;
            end
            default:
            begin
                emit_want = 1'b0;
            end
        endcase
        // runs past the result limit are dropped; the end marker always goes out
        emit_go = emit_want && (is_end || (runcnt_reg < gbd_pkg::MAX_RUNS));
        hold    = emit_go && !out_free;
    end

    // datapath next state
    always_comb
    begin
        before_count_next = before_count_reg;
        after_count_next  = after_count_reg;
        overflow_next     = overflow_reg;
        bi_next           = bi_reg;
        ai_next           = ai_reg;
        j_next            = j_reg;
        dstart_next       = dstart_reg;
        dact_next         = dact_reg;
        runcnt_next       = runcnt_reg;

        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_start_next = out_start_reg;
        out_len_next   = out_len_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && dout.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (!hold)
        begin
            if (emit_go)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = emit_kind;
                out_start_next = emit_start;
                out_len_next   = emit_len;
                out_ovf_next   = overflow_reg;
                out_last_next  = is_end;
                if (!is_end)
                begin
                    runcnt_next = runcnt_reg + 1'b1;
                end
            end

            case (uw.act)
                gbd_pkg::ACT_IDLE:
                begin
                    if (in_xfer)
                    begin
                        case (din.func)
                            gbd_pkg::FN_LOAD_B:
                            begin
                                if (we_b)
                                begin
                                    before_count_next = before_count_reg + 1'b1;
                                end
                                else
                                begin
                                    overflow_next = 1'b1;
                                end
                            end
                            gbd_pkg::FN_LOAD_A:
                            begin
                                if (we_a)
                                begin
                                    after_count_next = after_count_reg + 1'b1;
                                end
                                else
                                begin
                                    overflow_next = 1'b1;
                                end
                            end
                            gbd_pkg::FN_CMP:
                            begin
                                bi_next     = '0;
                                ai_next     = '0;
                                dact_next   = 1'b0;
                                runcnt_next = '0;
                            end
                            default:
                            begin
                                overflow_next = overflow_reg;
                            end
                        endcase
                    end
                end
                gbd_pkg::ACT_MATCH:
                begin
                    dact_next = 1'b0;
                    bi_next   = bi_reg + 1'b1;
                    ai_next   = ai_reg + 1'b1;
                end
                gbd_pkg::ACT_SETJ:
                begin
                    j_next = ai_reg;
                end
                gbd_pkg::ACT_EMIT_DEL, gbd_pkg::ACT_FIN_DEL:
                begin
                    dact_next = 1'b0;
                end
                gbd_pkg::ACT_EMIT_INS:
                begin
                    ai_next = j_reg;
                end
                gbd_pkg::ACT_INCJ:
                begin
                    j_next = j_reg + 1'b1;
                end
                gbd_pkg::ACT_DEL_MARK:
                begin
                    if (!dact_reg)
                    begin
                        dact_next   = 1'b1;
                        dstart_next = bi_reg[AW-1:0];
                    end
                    bi_next = bi_reg + 1'b1;
                end
                gbd_pkg::ACT_DEL_TAIL:
                begin
                    if (!dact_reg)
                    begin
                        dact_next   = 1'b1;
                        dstart_next = bi_reg[AW-1:0];
                    end
                    bi_next = before_count_reg;
                end
                gbd_pkg::ACT_END:
                begin
                    before_count_next = '0;
                    after_count_next  = '0;
                    overflow_next     = 1'b0;
                end
                default:
                begin
                    dact_next = dact_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            before_count_reg <= '0;
            after_count_reg  <= '0;
            overflow_reg     <= 1'b0;
            bi_reg           <= '0;
            ai_reg           <= '0;
            j_reg            <= '0;
            dact_reg         <= 1'b0;
            runcnt_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            before_count_reg <= before_count_next;
            after_count_reg  <= after_count_next;
            overflow_reg     <= overflow_next;
            bi_reg           <= bi_next;
            ai_reg           <= ai_next;
            j_reg            <= j_next;
            dact_reg         <= dact_next;
            runcnt_reg       <= runcnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        dstart_reg    <= dstart_next;
        out_kind_reg  <= out_kind_next;
        out_start_reg <= out_start_next;
        out_len_reg   <= out_len_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    assign dout.valid      = out_valid_reg;
    assign dout.run_kind   = out_kind_reg;
    assign dout.run_start  = out_start_reg;
    assign dout.run_length = out_len_reg;
    assign dout.overflow   = out_ovf_reg;
    assign dout.last       = out_last_reg;

    // a compare starts with fresh cursors and closes the input
    `GBD_ASSERT_NEXT(a_cmp_start, clk, rst_n, cmp_accept, (bi_reg == '0) && (ai_reg == '0) && !dact_reg && !din.ready)

    // loading the end marker empties both strings and reopens the input
    `GBD_ASSERT_NEXT(a_end_clears, clk, rst_n, emit_go && is_end && out_free, (before_count_reg == '0) && (after_count_reg == '0) && !overflow_reg && din.ready)

    // an open deleted run always covers at least one byte inside the string
    `GBD_ASSERT_IMPL(a_del_open, clk, rst_n, dact_reg, (dstart_ext < bi_reg) && (bi_reg <= before_count_reg))

endmodule
